@@ hw/rtl/fdl_pkg.sv @@
package fdl_pkg;

	// Operation codes carried by the op field.
	localparam logic [1:0] OP_PROCESS = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_WRITE   = 2'd2;

	// Interpolation modes held in the interp_mode register.
	localparam logic [1:0] MODE_NEAREST = 2'd0;
	localparam logic [1:0] MODE_LINEAR  = 2'd1;
	localparam logic [1:0] MODE_HERMITE = 2'd2;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERP_MODE = 1'b1;

	// Main sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_READ,
		ST_LAST,
		ST_CALC,
		ST_DONE
	} fdl_state_t;

	// Control handed from the sequencer to the interpolation unit.
	typedef struct packed {
		logic start;
		logic cubic;
	} fdl_calc_ctrl_t;

endpackage

@@ hw/rtl/fractional_delay_line_top.sv @@
// Fractional delay line over a circular sample store held in one RAM.
// Requests arrive on the in_valid/in_ready channel with op, in_sample and
// delay_amount. Every request gives exactly one out_sample on the
// out_valid/out_ready channel, in request order; write-only requests and
// reads with a negative delay return zero.
// A request is processed one at a time. With the receiver ready, out_valid
// rises on the same edge at which in_ready returns. The spacing between
// accepted requests is set by the single RAM read port, which fetches one
// tap per cycle (one for a nearest read, two for linear, four for Hermite),
// and by the Horner evaluation, which runs one multiply and add per cycle.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; if the receiver stalls, the block finishes the
// next request and then holds in its final state until the output frees up.
// Configuration writes (line_length, interp_mode) are always accepted and are
// meant to come only while the block is idle. Reset, and every line_length
// write, empty the store at once: a fill count marks which slots were written
// since, and unwritten slots read as zero, so no clearing pass is needed.
module fractional_delay_line_top import fdl_pkg::*; #(
	parameter int MAX_DEPTH = 65536,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS = 8,
	localparam int ADDR_W = $clog2(MAX_DEPTH),
	localparam int LEN_W = ADDR_W + 1,
	localparam int DELAY_W = LEN_W + FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [LEN_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic signed [DELAY_W-1:0]     delay_amount,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_sample
);

	localparam int MAG_W = ADDR_W + FRAC_BITS;
	localparam int DN_W = MAG_W + 1;
	localparam logic [DN_W-1:0] ROUND_HALF = DN_W'(64'd1 << (FRAC_BITS - 1));

	// Configuration and line state.
	logic [LEN_W-1:0]  line_length_q;
	logic [1:0]        mode_q;
	logic [ADDR_W-1:0] wp_q;
	logic [LEN_W-1:0]  fill_q;

	// Request registers.
	logic [1:0]                    op_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [DELAY_W-1:0]            delay_q;

	// Tap plan built in the prepare state.
	logic [ADDR_W-1:0]    k_q [4];
	logic [FRAC_BITS-1:0] t_q;
	logic [1:0]           rd_idx_q;
	logic [1:0]           rd_last_q;
	logic                 zero_q;
	logic                 calc_q;
	logic                 cubic_q;

	// Read pipeline and fetched taps.
	logic                          rd_v_s1;
	logic [1:0]                    rd_slot_s1;
	logic                          hit_s1;
	logic signed [SAMPLE_BITS-1:0] y_q [4];

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;

	fdl_state_t state_q;
	fdl_state_t state_d;

	// Prepare-state arithmetic.
	logic [LEN_W-1:0]     last_full;
	logic [ADDR_W-1:0]    last;
	logic [MAG_W-1:0]     mag;
	logic [MAG_W-1:0]     lim;
	logic [MAG_W-1:0]     d_clamp;
	logic [DN_W-1:0]      dn;
	logic [ADDR_W-1:0]    idx_i;
	logic [FRAC_BITS-1:0] frac;
	logic [ADDR_W-1:0]    kn;
	logic [ADDR_W-1:0]    i_p1;
	logic [ADDR_W-1:0]    k0;
	logic [ADDR_W-1:0]    k2;
	logic [ADDR_W-1:0]    k3;
	logic                 at_last;
	logic                 is_read_op;
	logic                 is_write_op;
	logic                 mode_nearest;
	logic                 mode_linear;
	logic                 mode_hermite;
	logic                 do_read;

	// Read address arithmetic.
	logic [ADDR_W-1:0] k_sel;
	logic [LEN_W-1:0]  diff;
	logic [LEN_W-1:0]  pos_sum;
	logic [ADDR_W-1:0] pos;
	logic              hit;

	// Sequencer outputs.
	logic           mem_re;
	logic           mem_we;
	logic           out_load;
	fdl_calc_ctrl_t calc_ctrl;

	logic [SAMPLE_BITS-1:0]        rdata;
	logic                          calc_done;
	logic signed [SAMPLE_BITS-1:0] calc_result;
	logic [LEN_W-1:0]              len_wr;
	logic [ADDR_W-1:0]             wp_inc;

	// The delay is clamped to line_length-1 samples, then split into the
	// integer tap distance and the fraction.
	always_comb begin
		last_full = line_length_q - LEN_W'(1);
		last = last_full[ADDR_W-1:0];
		mag = delay_q[MAG_W-1:0];
		lim = {last, {FRAC_BITS{1'b0}}};
		d_clamp = (mag > lim) ? lim : mag;
		idx_i = d_clamp[MAG_W-1:FRAC_BITS];
		frac = d_clamp[FRAC_BITS-1:0];
		dn = {1'b0, d_clamp} + ROUND_HALF;
		kn = dn[DN_W-2:FRAC_BITS];
		at_last = (idx_i == last);
		i_p1 = idx_i + ADDR_W'(1);
		k0 = (idx_i == '0) ? '0 : idx_i - ADDR_W'(1);
		k2 = at_last ? last : i_p1;
		k3 = (at_last || i_p1 == last) ? last : idx_i + ADDR_W'(2);
		is_read_op = (op_q == OP_PROCESS) || (op_q == OP_READ);
		is_write_op = (op_q == OP_PROCESS) || (op_q == OP_WRITE);
		mode_nearest = (mode_q == MODE_NEAREST);
		mode_linear = (mode_q == MODE_LINEAR);
		mode_hermite = (mode_q == MODE_HERMITE);
		// A negative delay or an undefined mode gives zero without reading.
		do_read = is_read_op && !delay_q[DELAY_W-1]
			&& (mode_nearest || mode_linear || mode_hermite);
	end

	// Tap k sits k slots behind the write position, modulo the line length.
	// Slots written since the last clear are exactly those below fill_q.
	always_comb begin
		k_sel = k_q[rd_idx_q];
		diff = {1'b0, wp_q} - {1'b0, k_sel};
		pos_sum = diff[ADDR_W] ? (diff + line_length_q) : diff;
		pos = pos_sum[ADDR_W-1:0];
		hit = ({1'b0, pos} < fill_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = do_read ? ST_READ : ST_LAST;
			end
			ST_READ: begin
				if (rd_idx_q == rd_last_q) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = calc_q ? ST_CALC : ST_DONE;
			end
			ST_CALC: begin
				if (calc_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The write of a process request lands after all its taps are fetched,
	// so the read always sees the store as it was before the request.
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		mem_re = (state_q == ST_READ);
		mem_we = (state_q == ST_LAST) && is_write_op;
		calc_ctrl.start = (state_q == ST_LAST) && calc_q;
		calc_ctrl.cubic = cubic_q;
		out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_comb begin
		len_wr = cfg_data;
		if (cfg_data == '0) begin
			len_wr = LEN_W'(1);
		end else if (cfg_data > LEN_W'(MAX_DEPTH)) begin
			len_wr = LEN_W'(MAX_DEPTH);
		end
		wp_inc = ({1'b0, wp_q} + LEN_W'(1) == line_length_q) ? '0 : wp_q + ADDR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_length_q <= LEN_W'(MAX_DEPTH);
			mode_q <= MODE_NEAREST;
			wp_q <= '0;
			fill_q <= '0;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			rd_idx_q <= '0;
			rd_last_q <= '0;
			zero_q <= 1'b0;
			calc_q <= 1'b0;
			cubic_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= mem_re;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_LINE_LENGTH: begin
						line_length_q <= len_wr;
						wp_q <= '0;
						fill_q <= '0;
					end
					REG_INTERP_MODE: begin
						mode_q <= cfg_data[1:0];
					end
					default: begin
					end
				endcase
			end else if (mem_we) begin
				wp_q <= wp_inc;
				if (fill_q < line_length_q) begin
					fill_q <= fill_q + LEN_W'(1);
				end
			end

			if (state_q == ST_PREP) begin
				rd_idx_q <= mode_hermite ? 2'd0 : 2'd1;
				rd_last_q <= mode_hermite ? 2'd3 : (mode_linear ? 2'd2 : 2'd1);
				zero_q <= !do_read;
				calc_q <= do_read && (mode_linear || mode_hermite);
				cubic_q <= mode_hermite;
			end else if (mem_re) begin
				rd_idx_q <= rd_idx_q + 2'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= op;
			sample_q <= in_sample;
			delay_q <= delay_amount;
		end
		if (state_q == ST_PREP) begin
			// Nearest uses slot 1 only, linear slots 1 and 2, Hermite all four.
			k_q[0] <= k0;
			k_q[1] <= mode_nearest ? kn : idx_i;
			k_q[2] <= k2;
			k_q[3] <= k3;
			t_q <= (mode_linear && at_last) ? '0 : frac;
		end
		if (mem_re) begin
			rd_slot_s1 <= rd_idx_q;
			hit_s1 <= hit;
		end
		if (rd_v_s1) begin
			y_q[rd_slot_s1] <= hit_s1 ? $signed(rdata) : '0;
		end
		if (out_load) begin
			if (zero_q) begin
				out_sample_q <= '0;
			end else if (calc_q) begin
				out_sample_q <= calc_result;
			end else begin
				out_sample_q <= y_q[1];
			end
		end
	end

	fdl_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (sample_q),
		.re    (mem_re),
		.raddr (pos),
		.rdata (rdata)
	);

	fdl_interp #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (calc_ctrl),
		.frac   (t_q),
		.y      (y_q),
		.done   (calc_done),
		.result (calc_result)
	);

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;

endmodule

@@ hw/rtl/fdl_ram.sv @@
module fdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/fdl_interp.sv @@
module fdl_interp import fdl_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fdl_calc_ctrl_t                ctrl,
	input  logic [FRAC_BITS-1:0]          frac,
	input  logic signed [SAMPLE_BITS-1:0] y [4],
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] result
);

	// Horner accumulator wide enough for the largest Catmull-Rom intermediate.
	localparam int H_W = SAMPLE_BITS + 5;
	localparam int P_W = H_W + FRAC_BITS + 1;
	localparam logic signed [P_W-1:0] HALF = P_W'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [H_W-1:0] SAT_HI = H_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [H_W-1:0] SAT_LO = H_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
	localparam logic [1:0] LIN_LAST_STEP = 2'd1;
	localparam logic [1:0] CUBIC_LAST_STEP = 2'd3;

	logic                  busy_q;
	logic                  done_q;
	logic                  cubic_q;
	logic [1:0]            step_q;
	logic signed [H_W-1:0] h_q;
	logic signed [H_W-1:0] c1_q;
	logic signed [H_W-1:0] c2_q;

	logic signed [H_W-1:0] ye [4];
	logic signed [H_W-1:0] c1;
	logic signed [H_W-1:0] c2;
	logic signed [H_W-1:0] c3;
	logic signed [H_W-1:0] d12;
	logic signed [H_W-1:0] h_init;
	logic signed [H_W-1:0] addend;
	logic signed [FRAC_BITS:0] frac_s;
	logic signed [P_W-1:0] prod;
	logic signed [P_W-1:0] prod_rnd;
	logic signed [H_W-1:0] h_step;
	logic signed [H_W-1:0] h_final;
	logic [1:0]            last_step;

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			ye[n] = H_W'(y[n]);
		end
		d12 = ye[1] - ye[2];
		c1 = ye[2] - ye[0];
		c2 = (ye[0] <<< 1) - (ye[1] <<< 2) - ye[1] + (ye[2] <<< 2) - ye[3];
		c3 = ye[3] - ye[0] + (d12 <<< 1) + d12;
		// Linear mode runs one Horner step on the slope y2 - y1.
		h_init = cubic_q ? c3 : (ye[2] - ye[1]);
	end

	always_comb begin
		if (!cubic_q) begin
			addend = ye[1];
		end else begin
			case (step_q)
				2'd1:    addend = c2_q;
				2'd2:    addend = c1_q;
				default: addend = ye[1] <<< 1;
			endcase
		end
		frac_s = $signed({1'b0, frac});
		prod = P_W'(h_q) * P_W'(frac_s);
		prod_rnd = (prod + HALF) >>> FRAC_BITS;
		h_step = prod_rnd[H_W-1:0] + addend;
		last_step = cubic_q ? CUBIC_LAST_STEP : LIN_LAST_STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cubic_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !ctrl.start && (step_q == last_step);
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cubic_q <= ctrl.cubic;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Step zero loads the coefficients, each later step is one Horner update.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (step_q == 2'd0) begin
				h_q <= h_init;
				c1_q <= c1;
				c2_q <= c2;
			end else begin
				h_q <= h_step;
			end
		end
	end

	always_comb begin
		h_final = cubic_q ? ((h_q + H_W'(1)) >>> 1) : h_q;
		if (h_final > SAT_HI) begin
			result = SAT_HI[SAMPLE_BITS-1:0];
		end else if (h_final < SAT_LO) begin
			result = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			result = h_final[SAMPLE_BITS-1:0];
		end
	end

	assign done = done_q;

endmodule
